/* design/u8d_pkg.sv */
// shared types and constants for the utf-8 decoder with position tracking
`default_nettype none
package u8d_pkg;

    localparam int CP_W  = 21;
    localparam int POS_W = 24;
    localparam int BYTE_W = 8;
    localparam int TDATA_OUT_W = 72;

    localparam logic [CP_W-1:0] NEWLINE_CP = CP_W'(8'h0A);

    // one decoded event: a character, or a run of error characters for a cut sequence
    typedef struct packed {
        logic [1:0]      count;
        logic [CP_W-1:0] cp;
        logic            bad;
        logic            last;
    } u8d_desc_t;

endpackage
`default_nettype wire

/* design/utf8_decoder_with_position.sv */
// Streaming UTF-8 decoder with line and column tagging.
//
// Input channel (s_): one source byte per item in s_tdata[7:0]; s_tlast marks the
// final byte of a text. Result channel (m_): one decoded character per item with
// code point, line and column in m_tdata, m_tuser set for an invalid lead byte or
// a sequence cut by the end of text, and m_tlast on the final character.
// Bytes that only extend an open sequence produce no result item.
// A completed character passes through the descriptor register and then the output
// register. Throughput is one byte per cycle while the receiver keeps up; a
// sequence cut by s_tlast expands into up to three error characters, sent one per
// cycle from the result stage while m_tready is high; the input holds off meanwhile.
// Reset (aresetn low, synchronous) clears any open sequence, empties both
// registers and returns the position to line 1, column 0; the same position reset
// follows every final character. When the receiver stalls, the output register
// holds its item and the descriptor register behind it fills, after which
// s_tready drops; nothing is lost or repeated.
`default_nettype none
module utf8_decoder_with_position (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [u8d_pkg::BYTE_W-1:0]         s_tdata,  // byte_in[7:0]
    input  wire                                s_tlast,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // code_point[20:0], line_number[44:21], column_number[68:45], zero[71:69]
    output logic [u8d_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                               m_tuser,  // bad_sequence
    output logic                               m_tlast
);
    import u8d_pkg::*;

    logic      desc_valid;
    logic      desc_take;
    u8d_desc_t desc;

    u8d_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .desc_take  (desc_take),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    u8d_expand u_expand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_take  (desc_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

/* design/u8d_decode.sv */
// sequence assembly: registers a descriptor for each character or error
`default_nettype none
module u8d_decode (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [u8d_pkg::BYTE_W-1:0]   s_tdata,
    input  wire                          s_tlast,
    input  wire                          desc_take,
    output logic                         desc_valid,
    output u8d_pkg::u8d_desc_t           desc
);
    import u8d_pkg::*;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [2:0]      expected_reg, expected_next;
    logic [1:0]      held_reg, held_next;
    logic            desc_valid_reg;
    u8d_desc_t       desc_reg;
    u8d_desc_t       dec;
    logic [2:0]      cnt;
    logic [2:0]      diff;
    logic [CP_W-1:0] cont_bits;
    logic [CP_W-1:0] assembled;
    logic            accept;

    assign s_tready   = !desc_valid_reg || desc_take;
    assign accept     = s_tvalid && s_tready;
    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

    assign cnt  = {1'b0, held_reg} + 3'd1;
    assign diff = expected_reg - cnt;

    always_comb begin
        case (diff[1:0])
            2'd0:    cont_bits = CP_W'(s_tdata[5:0]);
            2'd1:    cont_bits = CP_W'({s_tdata[5:0], 6'd0});
            2'd2:    cont_bits = CP_W'({s_tdata[5:0], 12'd0});
            default: cont_bits = '0;
        endcase
    end

    assign assembled = partial_reg | cont_bits;

    always_comb begin
        partial_next  = partial_reg;
        expected_next = expected_reg;
        held_next     = held_reg;
        dec.count     = 2'd0;
        dec.cp        = '0;
        dec.bad       = 1'b0;
        dec.last      = s_tlast;
        if (expected_reg == 3'd0) begin
            if (!s_tdata[7]) begin
                dec.count = 2'd1;
                dec.cp    = CP_W'(s_tdata);
            end else if (s_tdata[7:5] == 3'b110) begin
                partial_next  = CP_W'({s_tdata[4:0], 6'd0});
                expected_next = 3'd2;
                held_next     = 2'd1;
            end else if (s_tdata[7:4] == 4'b1110) begin
                partial_next  = CP_W'({s_tdata[3:0], 12'd0});
                expected_next = 3'd3;
                held_next     = 2'd1;
            end else if (s_tdata[7:3] == 5'b11110) begin
                partial_next  = CP_W'({s_tdata[2:0], 18'd0});
                expected_next = 3'd4;
                held_next     = 2'd1;
            end else begin
                dec.count = 2'd1;
                dec.bad   = 1'b1;
            end
            // lead byte of a multi-byte sequence on the final item
            if (s_tlast && dec.count == 2'd0) begin
                dec.count = 2'd1;
                dec.bad   = 1'b1;
            end
        end else begin
            if (cnt >= expected_reg) begin
                dec.count     = 2'd1;
                dec.cp        = assembled;
                partial_next  = '0;
                expected_next = 3'd0;
                held_next     = 2'd0;
            end else if (s_tlast) begin
                dec.count     = cnt[1:0];
                dec.bad       = 1'b1;
                partial_next  = '0;
                expected_next = 3'd0;
                held_next     = 2'd0;
            end else begin
                partial_next = assembled;
                held_next    = cnt[1:0];
            end
        end
        if (s_tlast) begin
            partial_next  = '0;
            expected_next = 3'd0;
            held_next     = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg    <= '0;
            expected_reg   <= 3'd0;
            held_reg       <= 2'd0;
            desc_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                partial_reg    <= partial_next;
                expected_reg   <= expected_next;
                held_reg       <= held_next;
                desc_valid_reg <= (dec.count != 2'd0);
            end else if (desc_take) begin
                desc_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            desc_reg <= dec;
        end
    end

`ifndef SYNTHESIS
    a_idle_held: assert property (@(posedge aclk) disable iff (!aresetn)
        expected_reg == 3'd0 |-> held_reg == 2'd0)
        else $error("held byte count without open sequence");
    a_held_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        expected_reg != 3'd0 |-> {1'b0, held_reg} < expected_reg && held_reg != 2'd0)
        else $error("held byte count out of range");
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> expected_reg == 3'd0 && desc_valid_reg)
        else $error("final item left sequence open or gave no character");
`endif
endmodule
`default_nettype wire

/* design/u8d_expand.sv */
// result stage: one character per cycle unless the output stalls, line and column tracking, output register
`default_nettype none
module u8d_expand (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                desc_valid,
    input  u8d_pkg::u8d_desc_t                 desc,
    output logic                               desc_take,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [u8d_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import u8d_pkg::*;

    logic [POS_W-1:0] line_reg, line_now;
    logic [POS_W-1:0] col_reg, col_now;
    logic             first_reg;
    logic [1:0]       idx_reg;
    logic             m_tvalid_reg;
    logic [CP_W-1:0]  cp_reg;
    logic [POS_W-1:0] line_out_reg, col_out_reg;
    logic             bad_reg, last_reg;
    logic             out_load, emit, is_final, res_last;

    assign out_load  = !m_tvalid_reg || m_tready;
    assign emit      = out_load && desc_valid;
    assign is_final  = idx_reg == (desc.count - 2'd1);
    assign desc_take = emit && is_final;
    assign res_last  = desc.last && is_final;

    always_comb begin
        line_now = line_reg;
        col_now  = col_reg;
        if (!first_reg) begin
            if (desc.cp == NEWLINE_CP) begin
                if (line_reg != '1) line_now = line_reg + POS_W'(1);
                col_now = '0;
            end else if (col_reg != '1) begin
                col_now = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg     <= POS_W'(1);
            col_reg      <= '0;
            first_reg    <= 1'b1;
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
                idx_reg      <= is_final ? 2'd0 : idx_reg + 2'd1;
                if (res_last) begin
                    // text ends here, next item starts over at line 1
                    line_reg  <= POS_W'(1);
                    col_reg   <= '0;
                    first_reg <= 1'b1;
                end else begin
                    line_reg  <= line_now;
                    col_reg   <= col_now;
                    first_reg <= 1'b0;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            cp_reg       <= desc.cp;
            line_out_reg <= line_now;
            col_out_reg  <= col_now;
            bad_reg      <= desc.bad;
            last_reg     <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, col_out_reg, line_out_reg, cp_reg};
    assign m_tuser  = bad_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_idx_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        desc_valid |-> idx_reg < desc.count)
        else $error("burst index beyond descriptor count");
    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> desc_valid)
        else $error("burst index set with no descriptor");
    a_first_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && first_reg |=> m_tvalid && line_out_reg == POS_W'(1) && col_out_reg == '0)
        else $error("first character of a text not at line 1 column 0");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> cp_reg == '0)
        else $error("error character with nonzero code point");
`endif
endmodule
`default_nettype wire
